/* src/isa_pkg.sv */
// types and constants shared by the integer stack alu and its divider
// no dependencies; compile first
package isa_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W = 4;
	localparam int DEPTH_W = 9;

	// opcodes
	localparam logic [OP_W-1:0] OP_PUSH  = 4'd0;
	localparam logic [OP_W-1:0] OP_POP   = 4'd1;
	localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
	localparam logic [OP_W-1:0] OP_MUL   = 4'd4;
	localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
	localparam logic [OP_W-1:0] OP_REM   = 4'd6;
	localparam logic [OP_W-1:0] OP_NOT   = 4'd7;
	localparam logic [OP_W-1:0] OP_GT    = 4'd8;
	localparam logic [OP_W-1:0] OP_DUP   = 4'd9;
	localparam logic [OP_W-1:0] OP_SWAP  = 4'd10;
	localparam logic [OP_W-1:0] OP_CLEAR = 4'd11;

	// values pushed when the divisor is zero
	localparam logic [DATA_W-1:0] DIV_BY_ZERO_Q = 32'd42;
	localparam logic [DATA_W-1:0] REM_BY_ZERO_R = 32'h0badc0de;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic signed [DATA_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [DEPTH_W-1:0]       stack_depth;
		logic                     stack_empty;
		logic                     underflow;
		logic                     overflow;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_rsp_t;

endpackage

/* src/isa_div.sv */
// radix-2 restoring signed divider, one quotient bit per cycle
// depends on isa_pkg; divisor must be non-zero
module isa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  isa_pkg::div_req_t req,
	output isa_pkg::div_rsp_t rsp
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIX  = 3'b100
	} dstate_t;

	localparam int W = isa_pkg::DATA_W;
	localparam int SW = $clog2(W);

	dstate_t        dst_q;
	logic [SW-1:0]  step_q;
	logic           done_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   dvs_q;
	logic           qneg_q;
	logic           rneg_q;
	logic [W-1:0]   q_out_q;
	logic [W-1:0]   r_out_q;

	logic [W:0]     shifted;
	logic [W+1:0]   diff;
	logic           fits;

	// trial subtraction of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~diff[W+1];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_q  <= D_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (dst_q)
				D_IDLE: begin
					if (req.start) begin
						dst_q  <= D_RUN;
						step_q <= '0;
					end
				end
				D_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(W - 1)) begin
						dst_q <= D_FIX;
					end
				end
				D_FIX: begin
					dst_q  <= D_IDLE;
					done_q <= 1'b1;
				end
				default: dst_q <= D_IDLE;
			endcase
		end
	end

	// datapath: magnitudes in, one bit per step, signs restored at the end
	always_ff @(posedge clk) begin
		if (dst_q == D_IDLE && req.start) begin
			quo_q  <= req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
			dvs_q  <= req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
			rem_q  <= '0;
			qneg_q <= req.dividend[W-1] ^ req.divisor[W-1];
			rneg_q <= req.dividend[W-1];
		end else if (dst_q == D_RUN) begin
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end else if (dst_q == D_FIX) begin
			q_out_q <= qneg_q ? (W'(0) - quo_q) : quo_q;
			r_out_q <= rneg_q ? (W'(0) - rem_q) : rem_q;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = q_out_q;
	assign rsp.remainder = r_out_q;

endmodule

/* src/integer_stack_alu_unit.sv */
// integer stack alu: a stack of signed 32-bit words under one opcode per beat
// depends on isa_pkg and isa_div
//
//   channel | direction | payload         | handshake
//   cmd     | in        | isa_pkg::cmd_t  | cmd_valid / cmd_stall
//   res     | out       | isa_pkg::res_t  | res_valid / res_stall
//
// each beat walks the states it needs: pops in S_POPA/S_POPB, alu in S_EXEC,
// pushes in S_PUSH1/S_PUSH2, top read in S_TOPRD, result in S_DONE; div and rem
// by a non-zero divisor wait in S_DIVW for the 32 iterations of the divider.
// the stack sits in a single-port-write, single-read memory: every pop, push
// and final top-of-stack read is one memory access in its own cycle.
// reset empties the stack at once; the memory contents are never cleared.
// cmd_stall is high while an item is at work; a result waiting on res_stall
// holds the sequencer in its last step but lets the next beat in once loaded.
module integer_stack_alu_unit #(
	parameter int STACK_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  isa_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output isa_pkg::res_t res
);

	localparam int W = isa_pkg::DATA_W;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int XW = (CW > isa_pkg::DEPTH_W) ? CW : isa_pkg::DEPTH_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_POPA  = 9'b000000010,
		S_POPB  = 9'b000000100,
		S_EXEC  = 9'b000001000,
		S_DIVW  = 9'b000010000,
		S_PUSH1 = 9'b000100000,
		S_PUSH2 = 9'b001000000,
		S_TOPRD = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	// control registers
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            under_q, under_d;
	logic            over_q, over_d;
	logic            rd_ok_q, rd_ok_d;
	logic            res_valid_q;

	// payload registers
	logic [isa_pkg::OP_W-1:0] op_q;
	logic [W-1:0]    pv_q;
	logic [W-1:0]    a_q;
	logic [W-1:0]    val_q;
	logic [W-1:0]    sec_q;
	logic [W-1:0]    rd_q;
	isa_pkg::res_t   out_q;

	logic [W-1:0]    stack_mem [STACK_DEPTH];

	logic            accept;
	logic            out_load;
	logic            two_pop;
	logic            is_divrem;
	logic [W-1:0]    opnd;
	logic [W-1:0]    op_a;
	logic [W-1:0]    op_b;
	logic [W-1:0]    exec_val;
	logic [W-1:0]    top_val;
	logic [CW-1:0]   cnt_m1;
	logic [XW-1:0]   cnt_x;
	logic            has_entry;
	logic            has_room;
	logic            rd_en;
	logic            mem_we;
	logic [W-1:0]    mem_wd;
	isa_pkg::div_req_t div_req;
	isa_pkg::div_rsp_t div_rsp;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!res_valid_q || !res_stall);

	assign cnt_m1    = cnt_q - 1'b1;
	assign cnt_x     = XW'(cnt_q);
	assign has_entry = (cnt_q != '0);
	assign has_room  = (cnt_q < CW'(STACK_DEPTH));

	// opcode classes
	always_comb begin
		two_pop   = 1'b0;
		is_divrem = 1'b0;
		case (op_q) inside
			isa_pkg::OP_ADD, isa_pkg::OP_SUB, isa_pkg::OP_MUL, isa_pkg::OP_GT,
			isa_pkg::OP_SWAP: two_pop = 1'b1;
			isa_pkg::OP_DIV, isa_pkg::OP_REM: begin
				two_pop   = 1'b1;
				is_divrem = 1'b1;
			end
			default: ;
		endcase
	end

	// operands: the last popped word, empty pops read as zero
	assign opnd = rd_ok_q ? rd_q : '0;
	assign op_a = two_pop ? a_q : opnd;
	assign op_b = two_pop ? opnd : '0;

	// shared alu for everything but division by a non-zero divisor
	always_comb begin
		case (op_q)
			isa_pkg::OP_PUSH: exec_val = pv_q;
			isa_pkg::OP_ADD:  exec_val = op_b + op_a;
			isa_pkg::OP_SUB:  exec_val = op_b - op_a;
			isa_pkg::OP_MUL:  exec_val = op_b * op_a;
			isa_pkg::OP_DIV:  exec_val = isa_pkg::DIV_BY_ZERO_Q;
			isa_pkg::OP_REM:  exec_val = isa_pkg::REM_BY_ZERO_R;
			isa_pkg::OP_NOT:  exec_val = W'(op_a == '0);
			isa_pkg::OP_GT:   exec_val = W'($signed(op_b) > $signed(op_a));
			default:          exec_val = op_a;
		endcase
	end

	assign div_req.start    = (state_q == S_EXEC) && is_divrem && (op_a != '0);
	assign div_req.dividend = op_b;
	assign div_req.divisor  = op_a;

	isa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		under_d = under_q;
		over_d  = over_q;
		rd_ok_d = rd_ok_q;
		rd_en   = 1'b0;
		mem_we  = 1'b0;
		mem_wd  = val_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					under_d = 1'b0;
					over_d  = 1'b0;
					case (cmd.opcode) inside
						isa_pkg::OP_PUSH: state_d = S_EXEC;
						isa_pkg::OP_CLEAR: begin
							cnt_d   = '0;
							state_d = S_TOPRD;
						end
						isa_pkg::OP_POP, isa_pkg::OP_ADD, isa_pkg::OP_SUB,
						isa_pkg::OP_MUL, isa_pkg::OP_DIV, isa_pkg::OP_REM,
						isa_pkg::OP_NOT, isa_pkg::OP_GT, isa_pkg::OP_DUP,
						isa_pkg::OP_SWAP: state_d = S_POPA;
						default: state_d = S_TOPRD;
					endcase
				end
			end
			S_POPA, S_POPB: begin
				rd_en = 1'b1;
				if (has_entry) begin
					rd_ok_d = 1'b1;
					cnt_d   = cnt_m1;
				end else begin
					rd_ok_d = 1'b0;
					under_d = 1'b1;
				end
				state_d = (state_q == S_POPA && two_pop) ? S_POPB : S_EXEC;
			end
			S_EXEC: begin
				if (op_q == isa_pkg::OP_POP) begin
					state_d = S_DONE;
				end else if (div_req.start) begin
					state_d = S_DIVW;
				end else begin
					state_d = S_PUSH1;
				end
			end
			S_DIVW: begin
				if (div_rsp.done) begin
					state_d = S_PUSH1;
				end
			end
			S_PUSH1, S_PUSH2: begin
				mem_wd = (state_q == S_PUSH1) ? val_q : sec_q;
				if (has_room) begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end else begin
					over_d = 1'b1;
				end
				if (state_q == S_PUSH1 &&
						(op_q == isa_pkg::OP_DUP || op_q == isa_pkg::OP_SWAP)) begin
					state_d = S_PUSH2;
				end else begin
					state_d = S_TOPRD;
				end
			end
			S_TOPRD: begin
				rd_en   = 1'b1;
				rd_ok_d = has_entry;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			under_q     <= 1'b0;
			over_q      <= 1'b0;
			rd_ok_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			under_q <= under_d;
			over_q  <= over_d;
			rd_ok_q <= rd_ok_d;
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// stack memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[cnt_q[AW-1:0]] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= stack_mem[cnt_m1[AW-1:0]];
		end
	end

	// operand and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd.opcode;
			pv_q <= cmd.push_value;
		end
		if (state_q == S_POPB) begin
			a_q <= opnd;
		end
		if (state_q == S_EXEC) begin
			val_q <= exec_val;
			sec_q <= (op_q == isa_pkg::OP_SWAP) ? op_b : op_a;
		end
		if (state_q == S_DIVW && div_rsp.done) begin
			val_q <= (op_q == isa_pkg::OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
		end
		if (out_load) begin
			out_q.result_value <= top_val;
			out_q.stack_depth  <= cnt_x[isa_pkg::DEPTH_W-1:0];
			out_q.stack_empty  <= ~has_entry;
			out_q.underflow    <= under_q;
			out_q.overflow     <= over_q;
		end
	end

	// pop reports the popped word, everything else the new top
	assign top_val = (op_q == isa_pkg::OP_POP) ? val_q : opnd;

	assign res_valid = res_valid_q;
	assign res       = out_q;

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("entry count beyond stack depth");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIVW)
		else $error("divider finished with nobody waiting");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted beat did not start the sequencer");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(under_q && over_q))
		else $error("underflow and overflow on the same beat");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for integer_stack_alu_unit: random and directed opcodes
// against a shadow stack. depends on isa_pkg and the unit's rtl
module testbench;

	localparam int DATA_W = isa_pkg::DATA_W;
	localparam int OP_W = isa_pkg::OP_W;
	localparam int DEPTH_W = isa_pkg::DEPTH_W;
	localparam int STACK_DEPTH = 256;
	localparam int RANDOM_ITEMS = 1900;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 60;
	// opcodes the unit leaves undecoded
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd12;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	typedef struct {
		isa_pkg::cmd_t beat;
		bit            drain_first;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	isa_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	isa_pkg::res_t res;

	pending_t pending[$];
	isa_pkg::res_t expected_results[$];
	isa_pkg::res_t want_res;

	// shadow stack
	logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
	int unsigned shadow_count;
	bit under_now, over_now;

	int unsigned cmds_sent, results_checked, fail_count;
	int unsigned peak_depth, overflow_results, underflow_results;
	int unsigned send_idle, recv_stall, quiet_cycles;
	bit send_calm, recv_calm;

	integer_stack_alu_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow stack access; an empty pop reads 0, a full push is dropped
	function automatic logic [DATA_W-1:0] shadow_pop();
		if (shadow_count == 0) begin
			under_now = 1'b1;
			return '0;
		end
		shadow_count--;
		return shadow_stack[shadow_count];
	endfunction

	function automatic void shadow_push(logic [DATA_W-1:0] value);
		if (shadow_count >= STACK_DEPTH) begin
			over_now = 1'b1;
			return;
		end
		shadow_stack[shadow_count] = value;
		shadow_count++;
	endfunction

	// run one opcode on the shadow stack and queue the result it must give
	function automatic void stack_alu_step(isa_pkg::cmd_t c);
		logic [DATA_W-1:0] a, b, top;
		longint num, den;
		isa_pkg::res_t want;
		under_now = 1'b0;
		over_now = 1'b0;
		top = '0;
		case (c.opcode)
			isa_pkg::OP_PUSH: shadow_push(c.push_value);
			isa_pkg::OP_POP: top = shadow_pop();
			isa_pkg::OP_ADD: begin
				a = shadow_pop();
				b = shadow_pop();
				shadow_push(b + a);
			end
			isa_pkg::OP_SUB: begin
				a = shadow_pop();
				b = shadow_pop();
				shadow_push(b - a);
			end
			isa_pkg::OP_MUL: begin
				a = shadow_pop();
				b = shadow_pop();
				shadow_push(b * a);
			end
			isa_pkg::OP_DIV, isa_pkg::OP_REM: begin
				a = shadow_pop();
				b = shadow_pop();
				num = longint'($signed(b));
				den = longint'($signed(a));
				// 64-bit division keeps most-negative over minus one well defined
				if (a == '0)
					shadow_push(c.opcode == isa_pkg::OP_DIV ? isa_pkg::DIV_BY_ZERO_Q
						: isa_pkg::REM_BY_ZERO_R);
				else if (c.opcode == isa_pkg::OP_DIV)
					shadow_push(DATA_W'(num / den));
				else
					shadow_push(DATA_W'(num % den));
			end
			isa_pkg::OP_NOT: begin
				a = shadow_pop();
				shadow_push({31'b0, a == '0});
			end
			isa_pkg::OP_GT: begin
				a = shadow_pop();
				b = shadow_pop();
				shadow_push({31'b0, $signed(b) > $signed(a)});
			end
			isa_pkg::OP_DUP: begin
				a = shadow_pop();
				shadow_push(a);
				shadow_push(a);
			end
			isa_pkg::OP_SWAP: begin
				a = shadow_pop();
				b = shadow_pop();
				shadow_push(a);
				shadow_push(b);
			end
			isa_pkg::OP_CLEAR: shadow_count = 0;
			default: ;
		endcase
		if (c.opcode != isa_pkg::OP_POP)
			top = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
		want.result_value = top;
		want.stack_depth = DEPTH_W'(shadow_count);
		want.stack_empty = (shadow_count == 0);
		want.underflow = under_now;
		want.overflow = over_now;
		expected_results.push_back(want);
		if (shadow_count > peak_depth)
			peak_depth = shadow_count;
		overflow_results += over_now;
		underflow_results += under_now;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void queue_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
			bit drain);
		pending_t item;
		item.beat.opcode = op;
		item.beat.push_value = value;
		item.drain_first = drain;
		pending.push_back(item);
	endfunction

	// extremes and small values so that zero divisors and ties turn up often
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return '0;
			4, 5, 6: return DATA_W'($urandom_range(0, 16) - 8);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return isa_pkg::OP_PUSH;
		if (r < 43)
			return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if (r < 45)
			return isa_pkg::OP_CLEAR;
		return OP_W'($urandom_range(isa_pkg::OP_POP, isa_pkg::OP_SWAP));
	endfunction

	// mostly short gaps, a few long ones, none while calm
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			shadow_count = 0;
			send_idle = 0;
		end else begin
			// beat taken: predict its result
			if (cmd_valid && !cmd_stall) begin
				stack_alu_step(cmd);
				cmds_sent++;
			end
			if ($urandom_range(0, 99) == 0)
				send_calm = !send_calm;
			// a stalled beat holds; otherwise idle, pause or load the next one
			if (!cmd_valid || !cmd_stall) begin
				if (send_idle > 0) begin
					send_idle--;
					cmd_valid <= 1'b0;
				end else if (pending.size() > 0 &&
						!(pending[0].drain_first && expected_results.size() > 0)) begin
					cmd <= pending[0].beat;
					cmd_valid <= 1'b1;
					void'(pending.pop_front());
					send_idle = pick_gap(send_calm);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_stall = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: value %0h depth %0d",
						res.result_value, res.stack_depth);
					fail_count++;
				end else begin
					want_res = expected_results.pop_front();
					check_field("result_value", want_res.result_value, res.result_value);
					check_field("stack_depth", want_res.stack_depth, res.stack_depth);
					check_field("stack_empty", want_res.stack_empty, res.stack_empty);
					check_field("underflow", want_res.underflow, res.underflow);
					check_field("overflow", want_res.overflow, res.overflow);
					results_checked++;
				end
			end
			if ($urandom_range(0, 99) == 0)
				recv_calm = !recv_calm;
			if (recv_stall > 0) begin
				recv_stall--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					recv_stall = pick_gap(recv_calm);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout after %0d idle cycles", QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned total, seg_len, fills;
		// empty-stack pops, wraps, zero divisors, sign of quotient and remainder
		queue_cmd(isa_pkg::OP_POP, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_ADD, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_DUP, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_CLEAR, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h7fff_ffff, 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h0000_0001, 1'b0);
		queue_cmd(isa_pkg::OP_ADD, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h8000_0000, 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'hffff_ffff, 1'b0);
		queue_cmd(isa_pkg::OP_DIV, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'hffff_ffff, 1'b0);
		queue_cmd(isa_pkg::OP_REM, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h0, 1'b0);
		queue_cmd(isa_pkg::OP_DIV, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h0, 1'b0);
		queue_cmd(isa_pkg::OP_REM, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'hffff_fff9, 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h0000_0002, 1'b0);
		queue_cmd(isa_pkg::OP_DIV, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_PUSH, 32'h0000_0002, 1'b0);
		queue_cmd(isa_pkg::OP_REM, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_NOT, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_GT, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_SWAP, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_SUB, pick_value(), 1'b0);
		queue_cmd(isa_pkg::OP_MUL, pick_value(), 1'b0);
		queue_cmd(OP_SPARE_LO, pick_value(), 1'b1);
		queue_cmd(OP_SPARE_HI, pick_value(), 1'b0);

		// random segments, with a few runs to a full stack and past it
		total = pending.size() + RANDOM_ITEMS;
		fills = 0;
		while (pending.size() < total) begin
			if (fills < 3 && pending.size() > 300 + fills * 550) begin
				fills++;
				queue_cmd(isa_pkg::OP_PUSH, $urandom(), 1'($urandom_range(0, 1)));
				repeat (STACK_DEPTH + $urandom_range(0, 3))
					queue_cmd(isa_pkg::OP_PUSH, $urandom(), 1'b0);
				queue_cmd(isa_pkg::OP_DUP, pick_value(), 1'b0);
				queue_cmd(isa_pkg::OP_SWAP, pick_value(), 1'b0);
				queue_cmd(isa_pkg::OP_PUSH, pick_value(), 1'b0);
			end
			seg_len = $urandom_range(8, 40);
			queue_cmd(pick_op(), pick_value(), $urandom_range(0, 9) == 0);
			repeat (seg_len - 1)
				queue_cmd(pick_op(), pick_value(), 1'b0);
		end
		total = pending.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmds_sent < total || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d opcodes sent, %0d results checked, %0d mismatches",
			cmds_sent, results_checked, fail_count);
		$display("stack peaked at %0d entries; %0d overflow and %0d underflow results",
			peak_depth, overflow_results, underflow_results);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
